// ===== rtl/json_byte_tokenizer_assert.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef JSON_BYTE_TOKENIZER_ASSERT_SVH
`define JSON_BYTE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define JBT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// Next-cycle implication.
`define JBT_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

// ===== rtl/jbt_pkg.sv =====
`default_nettype none
package jbt_pkg;

   // request and result payloads
   typedef struct packed {
      logic [7:0] byte_in;
      logic       stream_start;
   } req_type;

   typedef struct packed {
      logic [3:0]         kind;
      logic [7:0]         data_byte;
      logic               bool_value;
      logic               num_negative;
      logic [63:0]        mantissa;
      logic signed [15:0] dec_exponent;
      logic               mant_saturated;
      logic [2:0]         error_code;
      logic [23:0]        line;
      logic [15:0]        column;
      logic               last;
   } rsp_type;

   // one queue entry: all results of one request byte
   localparam int MaxEvents = 3;
   typedef struct packed {
      logic [1:0]             count;
      rsp_type [MaxEvents-1:0] ev;
   } entry_type;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   // result kinds
   localparam logic [3:0] KIND_LBRACE  = 4'd0;
   localparam logic [3:0] KIND_RBRACE  = 4'd1;
   localparam logic [3:0] KIND_LBRACK  = 4'd2;
   localparam logic [3:0] KIND_RBRACK  = 4'd3;
   localparam logic [3:0] KIND_COLON   = 4'd4;
   localparam logic [3:0] KIND_COMMA   = 4'd5;
   localparam logic [3:0] KIND_STR_END = 4'd6;
   localparam logic [3:0] KIND_STR_BYTE= 4'd7;
   localparam logic [3:0] KIND_NUMBER  = 4'd8;
   localparam logic [3:0] KIND_BOOL    = 4'd9;
   localparam logic [3:0] KIND_NULL    = 4'd10;
   localparam logic [3:0] KIND_END     = 4'd11;
   localparam logic [3:0] KIND_ERROR   = 4'd12;

   // error codes
   localparam logic [2:0] ERR_BAD_CHAR   = 3'd0;
   localparam logic [2:0] ERR_BAD_NUMBER = 3'd1;
   localparam logic [2:0] ERR_UNTERM_STR = 3'd2;
   localparam logic [2:0] ERR_BAD_ESC    = 3'd3;
   localparam logic [2:0] ERR_BAD_UNI    = 3'd4;

   // plain event with all number and bool fields cleared
   function automatic rsp_type mk_event(input logic [3:0] kind, input logic [7:0] data,
                                        input logic [2:0] ec, input logic [23:0] ln,
                                        input logic [15:0] cl);
      rsp_type r;
      r = '0;
      r.kind       = kind;
      r.data_byte  = data;
      r.error_code = ec;
      r.line       = ln;
      r.column     = cl;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/jbt_lexer.sv =====
`default_nettype none
module jbt_lexer import jbt_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   input  wire req_type   in_data,
   output logic           push,
   output entry_type      entry
);

   `include "json_byte_tokenizer_assert.svh"

   // lexer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_NSIGN  = 4'd1;
   localparam logic [3:0] S_NZERO  = 4'd2;
   localparam logic [3:0] S_NINT   = 4'd3;
   localparam logic [3:0] S_NDOT   = 4'd4;
   localparam logic [3:0] S_NFRAC  = 4'd5;
   localparam logic [3:0] S_NE     = 4'd6;
   localparam logic [3:0] S_NESIGN = 4'd7;
   localparam logic [3:0] S_NEXP   = 4'd8;
   localparam logic [3:0] S_STR    = 4'd9;
   localparam logic [3:0] S_ESC    = 4'd10;
   localparam logic [3:0] S_HEX    = 4'd11;
   localparam logic [3:0] S_KW     = 4'd12;

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_FF  = 8'h0C;
   localparam logic [23:0] LineMax = 24'hFFFFFF;
   localparam logic [15:0] ColMax  = 16'hFFFF;

   logic [3:0]         st_ff, st_in;
   logic               cr_ff, cr_in;
   logic [23:0]        ln_ff, ln_in, tln_ff, tln_in;
   logic [15:0]        cl_ff, cl_in, tcl_ff, tcl_in;
   logic [15:0]        hx_ff, hx_in;
   logic [1:0]         hc_ff, hc_in;
   logic [63:0]        mt_ff, mt_in;
   logic [14:0]        ex_ff, ex_in;
   logic signed [15:0] fr_ff, fr_in;
   logic [2:0]         sf_ff, sf_in;
   logic [7:0]         kf_ff, kf_in;
   logic               hl_ff, hl_in;
   rsp_type            ev [MaxEvents];
   logic [1:0]         n;

   // expected keyword character at position idx
   function automatic logic [7:0] kw_char(input logic [7:0] first, input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      if (first == "t") begin
         unique case (idx)
            3'd1: c = "r";
            3'd2: c = "u";
            3'd3: c = "e";
            default: c = 8'h00;
         endcase
      end else if (first == "f") begin
         unique case (idx)
            3'd1: c = "a";
            3'd2: c = "l";
            3'd3: c = "s";
            3'd4: c = "e";
            default: c = 8'h00;
         endcase
      end else begin
         unique case (idx)
            3'd1: c = "u";
            3'd2: c = "l";
            3'd3: c = "l";
            default: c = 8'h00;
         endcase
      end
      return c;
   endfunction

   // one byte step of the lexer
   always_comb begin
      logic [7:0]         b;
      logic               was_cr, is_dig, is_e, do_idle, add_req, add_frac, exp_req;
      logic               nib_ok;
      logic [3:0]         nib;
      logic [2:0]         kidx, klen;
      logic [67:0]        m10;
      logic signed [16:0] fsum;
      logic [18:0]        e10;
      logic signed [17:0] ne;
      logic [15:0]        c;
      b = in_data.byte_in;
      st_in = st_ff; cr_in = cr_ff; ln_in = ln_ff; cl_in = cl_ff;
      tln_in = tln_ff; tcl_in = tcl_ff; hx_in = hx_ff; hc_in = hc_ff;
      mt_in = mt_ff; ex_in = ex_ff; fr_in = fr_ff; sf_in = sf_ff;
      kf_in = kf_ff; hl_in = hl_ff;
      for (int i = 0; i < MaxEvents; i++) ev[i] = '0;
      n = 2'd0;
      do_idle = 1'b0; add_req = 1'b0; add_frac = 1'b0; exp_req = 1'b0;
      was_cr = 1'b0;
      is_dig = (b >= "0") && (b <= "9");
      is_e   = (b == "e") || (b == "E");
      nib_ok = 1'b1; nib = 4'd0;
      kidx = 3'd0; klen = 3'd0; m10 = '0; fsum = '0; e10 = '0; ne = '0; c = '0;

      // stream start restarts position and clears halt
      if (in_data.stream_start) begin
         ln_in = 24'd1; cl_in = 16'd0; tln_in = 24'd1; tcl_in = 16'd0;
         cr_in = 1'b0; hl_in = 1'b0; st_in = S_IDLE;
      end

      if (!hl_in) begin
         was_cr = cr_in;
         cr_in  = 1'b0;
         if (b != 8'h00 && !(b == CH_LF && was_cr) && cl_in != ColMax)
            cl_in = cl_in + 16'd1;

         unique case (st_in)
            S_IDLE: do_idle = 1'b1;
            S_KW: begin
               kidx = {1'b0, hc_in} + 3'd1;
               klen = (kf_in == "f") ? 3'd5 : 3'd4;
               if (kidx >= klen || b != kw_char(kf_in, kidx)) begin
                  ev[n] = mk_event(KIND_ERROR, kf_in, ERR_BAD_CHAR, ln_in, cl_in);
                  n = n + 2'd1; hl_in = 1'b1; st_in = S_IDLE;
               end else if (kidx == klen - 3'd1) begin
                  st_in = S_IDLE;
                  if (kf_in == "n") begin
                     ev[n] = mk_event(KIND_NULL, 8'h00, 3'd0, tln_in, tcl_in);
                  end else begin
                     ev[n] = mk_event(KIND_BOOL, 8'h00, 3'd0, tln_in, tcl_in);
                     ev[n].bool_value = (kf_in == "t");
                  end
                  n = n + 2'd1;
               end else begin
                  hc_in = hc_in + 2'd1;
               end
            end
            S_HEX: begin
               if (is_dig) nib = b[3:0];
               else if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f"))
                  nib = b[3:0] + 4'd9;
               else nib_ok = 1'b0;
               if (!nib_ok) begin
                  ev[n] = mk_event(KIND_ERROR, b, ERR_BAD_UNI, ln_in, cl_in);
                  n = n + 2'd1; hl_in = 1'b1; st_in = S_IDLE;
               end else begin
                  hx_in = {hx_in[11:0], nib};
                  if (hc_in != 2'd3) begin
                     hc_in = hc_in + 2'd1;
                  end else begin
                     c = hx_in;
                     st_in = S_STR;
                     // UTF-8 encoding of the code unit
                     if (c <= 16'h007F) begin
                        ev[0] = mk_event(KIND_STR_BYTE, c[7:0], 3'd0, tln_in, tcl_in);
                        n = 2'd1;
                     end else if (c <= 16'h07FF) begin
                        ev[0] = mk_event(KIND_STR_BYTE, 8'hC0 | {3'd0, c[10:6]}, 3'd0,
                                         tln_in, tcl_in);
                        ev[1] = mk_event(KIND_STR_BYTE, 8'h80 | {2'd0, c[5:0]}, 3'd0,
                                         tln_in, tcl_in);
                        n = 2'd2;
                     end else begin
                        ev[0] = mk_event(KIND_STR_BYTE, 8'hE0 | {4'd0, c[15:12]}, 3'd0,
                                         tln_in, tcl_in);
                        ev[1] = mk_event(KIND_STR_BYTE, 8'h80 | {2'd0, c[11:6]}, 3'd0,
                                         tln_in, tcl_in);
                        ev[2] = mk_event(KIND_STR_BYTE, 8'h80 | {2'd0, c[5:0]}, 3'd0,
                                         tln_in, tcl_in);
                        n = 2'd3;
                     end
                  end
               end
            end
            S_STR, S_ESC: begin
               if (b == 8'h00) begin
                  ev[n] = mk_event(KIND_ERROR, 8'h00, ERR_UNTERM_STR, ln_in, cl_in);
                  n = n + 2'd1; hl_in = 1'b1; st_in = S_IDLE;
               end else if (st_in == S_ESC) begin
                  st_in = S_STR;
                  priority case (b)
                     "\"", "\\", "/":
                        ev[0] = mk_event(KIND_STR_BYTE, b, 3'd0, tln_in, tcl_in);
                     "b": ev[0] = mk_event(KIND_STR_BYTE, CH_BS, 3'd0, tln_in, tcl_in);
                     "f": ev[0] = mk_event(KIND_STR_BYTE, CH_FF, 3'd0, tln_in, tcl_in);
                     "n": ev[0] = mk_event(KIND_STR_BYTE, CH_LF, 3'd0, tln_in, tcl_in);
                     "r": ev[0] = mk_event(KIND_STR_BYTE, CH_CR, 3'd0, tln_in, tcl_in);
                     "t": ev[0] = mk_event(KIND_STR_BYTE, CH_TAB, 3'd0, tln_in, tcl_in);
                     "u": begin
                        hx_in = 16'd0; hc_in = 2'd0; st_in = S_HEX;
                     end
                     default: begin
                        ev[0] = mk_event(KIND_ERROR, b, ERR_BAD_ESC, ln_in, cl_in);
                        hl_in = 1'b1; st_in = S_IDLE;
                     end
                  endcase
                  if (b != "u") n = 2'd1;
               end else if (b == "\\") begin
                  st_in = S_ESC;
               end else if (b == "\"") begin
                  st_in = S_IDLE;
                  ev[0] = mk_event(KIND_STR_END, 8'h00, 3'd0, tln_in, tcl_in);
                  n = 2'd1;
               end else if (b == CH_BS || b == CH_FF || b == CH_LF || b == CH_CR ||
                            b == CH_TAB) begin
                  ev[0] = mk_event(KIND_ERROR, b, ERR_BAD_CHAR, ln_in, cl_in);
                  n = 2'd1; hl_in = 1'b1; st_in = S_IDLE;
               end else begin
                  ev[0] = mk_event(KIND_STR_BYTE, b, 3'd0, tln_in, tcl_in);
                  n = 2'd1;
               end
            end
            S_NSIGN, S_NZERO, S_NINT, S_NDOT, S_NFRAC, S_NE, S_NESIGN, S_NEXP: begin
               // number body; do_idle marks the number as finished
               unique case (st_in)
                  S_NSIGN: begin
                     if (b == "0") st_in = S_NZERO;
                     else if (is_dig) begin add_req = 1'b1; st_in = S_NINT; end
                     else hl_in = 1'b1;
                  end
                  S_NINT: begin
                     if (is_dig) add_req = 1'b1;
                     else if (b == ".") st_in = S_NDOT;
                     else if (is_e) st_in = S_NE;
                     else do_idle = 1'b1;
                  end
                  S_NZERO: begin
                     if (b == ".") st_in = S_NDOT;
                     else if (is_e) st_in = S_NE;
                     else do_idle = 1'b1;
                  end
                  S_NDOT: begin
                     if (is_dig) begin
                        add_req = 1'b1; add_frac = 1'b1; st_in = S_NFRAC;
                     end else hl_in = 1'b1;
                  end
                  S_NFRAC: begin
                     if (is_dig) begin add_req = 1'b1; add_frac = 1'b1; end
                     else if (is_e) st_in = S_NE;
                     else do_idle = 1'b1;
                  end
                  S_NE: begin
                     if (b == "-") begin sf_in[1] = 1'b1; st_in = S_NESIGN; end
                     else if (b == "+") st_in = S_NESIGN;
                     else if (is_dig) begin exp_req = 1'b1; st_in = S_NEXP; end
                     else hl_in = 1'b1;
                  end
                  S_NESIGN: begin
                     if (is_dig) begin exp_req = 1'b1; st_in = S_NEXP; end
                     else hl_in = 1'b1;
                  end
                  default: begin
                     if (is_dig) exp_req = 1'b1;
                     else do_idle = 1'b1;
                  end
               endcase
               if (hl_in) begin
                  ev[0] = mk_event(KIND_ERROR, b, ERR_BAD_NUMBER, ln_in, cl_in);
                  n = 2'd1; st_in = S_IDLE;
               end
               if (do_idle) begin
                  // exponent minus kept fraction digits, clamped to 16 bits
                  ne = sf_in[1] ? -$signed({3'd0, ex_in}) : $signed({3'd0, ex_in});
                  ne = ne - {{2{fr_in[15]}}, fr_in};
                  ev[0] = mk_event(KIND_NUMBER, 8'h00, 3'd0, tln_in, tcl_in);
                  ev[0].num_negative   = sf_in[0];
                  ev[0].mantissa       = mt_in;
                  ev[0].mant_saturated = sf_in[2];
                  if (ne > 18'sd32767) ev[0].dec_exponent = 16'sh7FFF;
                  else if (ne < -18'sd32768) ev[0].dec_exponent = 16'sh8000;
                  else ev[0].dec_exponent = ne[15:0];
                  n = 2'd1; st_in = S_IDLE;
               end
            end
            default: st_in = S_IDLE;
         endcase

         // between-token handling, also for the byte that ended a number
         if (do_idle) begin
            if (b == " " || b == CH_TAB) begin
               cr_in = 1'b0;
            end else if (b == CH_CR) begin
               cr_in = 1'b1; cl_in = 16'd0;
               if (ln_in != LineMax) ln_in = ln_in + 24'd1;
            end else if (b == CH_LF) begin
               if (!was_cr) begin
                  cl_in = 16'd0;
                  if (ln_in != LineMax) ln_in = ln_in + 24'd1;
               end
            end else begin
               tln_in = ln_in; tcl_in = cl_in;
               priority case (b)
                  8'h00: begin ev[n] = mk_event(KIND_END, 8'h00, 3'd0, ln_in, cl_in);
                     n = n + 2'd1; end
                  "{": begin ev[n] = mk_event(KIND_LBRACE, 8'h00, 3'd0, ln_in, cl_in);
                     n = n + 2'd1; end
                  "}": begin ev[n] = mk_event(KIND_RBRACE, 8'h00, 3'd0, ln_in, cl_in);
                     n = n + 2'd1; end
                  "[": begin ev[n] = mk_event(KIND_LBRACK, 8'h00, 3'd0, ln_in, cl_in);
                     n = n + 2'd1; end
                  "]": begin ev[n] = mk_event(KIND_RBRACK, 8'h00, 3'd0, ln_in, cl_in);
                     n = n + 2'd1; end
                  ":": begin ev[n] = mk_event(KIND_COLON, 8'h00, 3'd0, ln_in, cl_in);
                     n = n + 2'd1; end
                  ",": begin ev[n] = mk_event(KIND_COMMA, 8'h00, 3'd0, ln_in, cl_in);
                     n = n + 2'd1; end
                  "\"": st_in = S_STR;
                  "t", "f", "n": begin kf_in = b; hc_in = 2'd0; st_in = S_KW; end
                  "-", "0", "1", "2", "3", "4", "5", "6", "7", "8", "9": begin
                     mt_in = 64'd0; ex_in = 15'd0; fr_in = 16'sd0; sf_in = 3'd0;
                     if (b == "-") begin sf_in = 3'd1; st_in = S_NSIGN; end
                     else if (b == "0") st_in = S_NZERO;
                     else begin add_req = 1'b1; st_in = S_NINT; end
                  end
                  default: begin
                     ev[n] = mk_event(KIND_ERROR, b, ERR_BAD_CHAR, ln_in, cl_in);
                     n = n + 2'd1; hl_in = 1'b1; st_in = S_IDLE;
                  end
               endcase
            end
         end

         // mantissa digit: shift-add by ten, overflow drops the digit and sets the saturated flag
         if (add_req) begin
            m10 = ({4'd0, mt_in} << 3) + ({4'd0, mt_in} << 1) + {64'd0, b[3:0]};
            if (sf_in[2] || m10[67:64] != 4'd0) begin
               // dropped integer digit raises the exponent, dropped fraction digit is lost
               sf_in[2] = 1'b1;
               fsum = add_frac ? {fr_in[15], fr_in} : ({fr_in[15], fr_in} - 17'sd1);
            end else begin
               mt_in = m10[63:0];
               fsum = add_frac ? ({fr_in[15], fr_in} + 17'sd1) : {fr_in[15], fr_in};
            end
            if (fsum > 17'sd32767) fr_in = 16'sh7FFF;
            else if (fsum < -17'sd32768) fr_in = 16'sh8000;
            else fr_in = fsum[15:0];
         end

         // exponent digit, saturating magnitude
         if (exp_req) begin
            e10 = ({4'd0, ex_in} << 3) + ({4'd0, ex_in} << 1) + {15'd0, b[3:0]};
            ex_in = (e10 > 19'd32767) ? 15'h7FFF : e10[14:0];
         end
      end

      // mark the final result of this byte
      for (int i = 0; i < MaxEvents; i++)
         if (n != 2'd0 && i == int'(n) - 1) ev[i].last = 1'b1;
   end

   assign push        = in_valid && (n != 2'd0);
   assign entry.count = n;
   assign entry.ev    = {ev[2], ev[1], ev[0]};

   // lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; cr_ff <= 1'b0; ln_ff <= 24'd1; cl_ff <= 16'd0;
         tln_ff <= 24'd1; tcl_ff <= 16'd0; hx_ff <= 16'd0; hc_ff <= 2'd0;
         mt_ff <= 64'd0; ex_ff <= 15'd0; fr_ff <= 16'sd0; sf_ff <= 3'd0;
         kf_ff <= 8'd0; hl_ff <= 1'b0;
      end else if (in_valid) begin
         st_ff <= st_in; cr_ff <= cr_in; ln_ff <= ln_in; cl_ff <= cl_in;
         tln_ff <= tln_in; tcl_ff <= tcl_in; hx_ff <= hx_in; hc_ff <= hc_in;
         mt_ff <= mt_in; ex_ff <= ex_in; fr_ff <= fr_in; sf_ff <= sf_in;
         kf_ff <= kf_in; hl_ff <= hl_in;
      end
   end

   // halted lexer stays silent until a stream start
   `JBT_ASSERT_IMP(a_halt_silent, hl_ff && in_valid && !in_data.stream_start, !push)
   // an error always halts
   `JBT_ASSERT_NXT(a_err_halts, push && entry.ev[0].kind == KIND_ERROR, hl_ff)

endmodule
`default_nettype wire

// ===== rtl/jbt_queue.sv =====
`default_nettype none
module jbt_queue import jbt_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      wr_en,
   input  wire entry_type wr_entry,
   output logic           full,
   input  wire logic      rd_en,
   output entry_type      rd_entry,
   output logic           empty
);

   `include "json_byte_tokenizer_assert.svh"

   entry_type              mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wp_ff, rp_ff;
   logic [QueuePtrW:0]     cnt_ff, cnt_in;

   assign full     = (cnt_ff == (QueuePtrW+1)'(QueueDepth));
   assign empty    = (cnt_ff == '0);
   assign rd_entry = mem_ff[rp_ff];

   // occupancy
   always_comb begin
      cnt_in = cnt_ff;
      if (wr_en && !rd_en) cnt_in = cnt_ff + 1'b1;
      else if (!wr_en && rd_en) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 1'b1;
         if (rd_en) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_entry;
   end

   `JBT_ASSERT_IMP(a_no_overflow, full, !wr_en)
   `JBT_ASSERT_IMP(a_no_underflow, empty, !rd_en)

endmodule
`default_nettype wire

// ===== rtl/jbt_drain.sv =====
`default_nettype none
module jbt_drain import jbt_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire entry_type head,
   input  wire logic      q_empty,
   output logic           q_pop,
   output rsp_type        rsp_data,
   output logic           empty,
   input  wire logic      pop
);

   `include "json_byte_tokenizer_assert.svh"

   logic [1:0] idx_ff, idx_in;
   logic       take;

   // walk the results of the head entry, one per pop
   assign empty    = q_empty;
   assign rsp_data = head.ev[idx_ff];
   assign take     = pop && !q_empty;
   assign q_pop    = take && (idx_ff == head.count - 2'd1);

   always_comb begin
      idx_in = idx_ff;
      if (q_pop) idx_in = 2'd0;
      else if (take) idx_in = idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 2'd0;
      else idx_ff <= idx_in;
   end

   `JBT_ASSERT_IMP(a_idx_in_entry, !q_empty, idx_ff < head.count)

endmodule
`default_nettype wire

// ===== rtl/json_byte_tokenizer.sv =====
// JSON byte tokenizer. One text byte is accepted per clock while full is low;
// each byte is lexed in the cycle it is accepted and yields zero to three
// results (a number and the token that ended it, or the UTF-8 bytes of a \u
// escape), which wait in a four-entry queue of per-byte result groups and are
// delivered one per pop. Input runs at one byte per cycle as long as results
// are popped at least as fast as they are made; full rises only when the
// queue holds four byte groups not yet drained, so the output pop rate sets
// the sustained figure when bytes produce more than one result each.
`default_nettype none
module json_byte_tokenizer import jbt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   logic      accept, lx_push, q_pop, q_empty;
   entry_type lx_entry, q_head;

   assign accept = push && !full;

   jbt_lexer u_lexer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_data  (req_data),
      .push     (lx_push),
      .entry    (lx_entry)
   );

   jbt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (lx_push),
      .wr_entry (lx_entry),
      .full     (full),
      .rd_en    (q_pop),
      .rd_entry (q_head),
      .empty    (q_empty)
   );

   jbt_drain u_drain (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_data (rsp_data),
      .empty    (empty),
      .pop      (pop)
   );

endmodule
`default_nettype wire
